/* rtl/blcr_pkg.sv */
// Package for the banked language card RAM: payload word types, the card
// state record and the operation codes. No dependencies.
package blcr_pkg;

    localparam int RAM_ADDR_W = 17;              // 128 KiB of card RAM
    localparam int RAM_DEPTH  = 1 << RAM_ADDR_W;

    localparam logic [1:0] OP_SWITCH = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;

    localparam logic [7:0] IDLE_BYTE = 8'hFF;    // bus value when no RAM byte is driven
    localparam logic [2:0] HIGH_WINDOW = 3'b111; // A15..A13 of E000-FFFF

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  switch_offset;
        logic [15:0] mem_address;
        logic [7:0]  write_data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_enabled;
        logic       write_enabled;
        logic       inhibit_changed;
        logic [2:0] main_bank_out;
        logic       second_d_bank;
    } t_out_word;

    typedef struct packed {
        logic       read_en;
        logic       write_en;
        logic       d_sub_bank;
        logic [2:0] main_bank;
    } t_card_state;

endpackage

/* rtl/banked_language_card_ram.sv */
// Top level of the 128 KiB banked language card RAM.
// Depends on blcr_pkg, blcr_switch and blcr_ram.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries one bus word:
//   a soft switch touch, a read or a write in the D000-FFFF window. Output
//   channel (o_out_valid / i_out_stall / o_out_word) returns one result word
//   per input word, in order: the read byte (FF unless a RAM read) and the
//   card state after the word.
//   Result path: a result is held in the RAM read register and stage A,
//   then in the output register.
//   Throughput: one word per cycle when the input is not stalled, set by the
//   single RAM port which takes the read or write in the accept cycle.
//   Reset: switch state clears at once; then the RAM is zeroed one byte per
//   cycle, all 131072 bytes, with o_in_stall held high the whole time.
//   Output stall: a stage A register and the output register hold two
//   results; with both full the input stalls until the receiver takes one.
module banked_language_card_ram (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  blcr_pkg::t_in_word i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output blcr_pkg::t_out_word o_out_word
);
    import blcr_pkg::*;

    // card state from the switch block
    t_card_state cur_state;
    t_card_state next_state;
    logic        inhibit_changed;

    // handshake
    logic in_accept;
    logic a_advance;

    // RAM port
    logic                  ram_we;
    logic                  ram_re;
    logic [RAM_ADDR_W-1:0] ram_addr;
    logic [RAM_ADDR_W-1:0] map_addr;
    logic [7:0]            ram_wdata;
    logic [7:0]            ram_rdata;

    // clearing sweep after reset
    logic                  r_clr_busy, n_clr_busy;
    logic [RAM_ADDR_W-1:0] r_clr_addr, n_clr_addr;

    // stage A: state result waiting for the RAM read data
    logic      r_a_valid, n_a_valid;
    logic      r_a_is_read;
    t_out_word r_a_word;

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_word r_out_word;
    t_out_word out_word_d;

    assign a_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clr_busy || (r_a_valid && !a_advance);
    assign in_accept  = i_in_valid && !o_in_stall;

    blcr_switch u_switch (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_word           (i_in_word),
        .o_state          (cur_state),
        .o_next           (next_state),
        .o_inhibit_changed(inhibit_changed)
    );

    // window mapping: D000-DFFF (and anything below E000) goes to sub-bank
    // 0 or 1 of the main bank, E000-FFFF to bank offsets 2000-3FFF
    always_comb begin
        if (i_in_word.mem_address[15:13] == HIGH_WINDOW) begin
            map_addr = {cur_state.main_bank, 1'b1, i_in_word.mem_address[12:0]};
        end else begin
            map_addr = {cur_state.main_bank, 1'b0, cur_state.d_sub_bank,
                        i_in_word.mem_address[11:0]};
        end
    end

    assign ram_we    = r_clr_busy ||
                       (in_accept && (i_in_word.operation == OP_WRITE) && cur_state.write_en);
    assign ram_re    = in_accept && (i_in_word.operation == OP_READ);
    assign ram_addr  = r_clr_busy ? r_clr_addr : map_addr;
    assign ram_wdata = r_clr_busy ? 8'h00 : i_in_word.write_data;

    blcr_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // sweep every RAM byte to zero once after reset
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_comb begin
        n_a_valid = r_a_valid;
        if (in_accept) begin
            n_a_valid = 1'b1;
        end else if (a_advance) begin
            n_a_valid = 1'b0;
        end
        n_out_valid = a_advance ? r_a_valid : r_out_valid;

        out_word_d           = r_a_word;
        out_word_d.read_data = r_a_is_read ? ram_rdata : IDLE_BYTE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_busy  <= n_clr_busy;
            r_clr_addr  <= n_clr_addr;
            r_a_valid   <= n_a_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_is_read              <= (i_in_word.operation == OP_READ);
            r_a_word.read_data       <= IDLE_BYTE;
            r_a_word.read_enabled    <= next_state.read_en;
            r_a_word.write_enabled   <= next_state.write_en;
            r_a_word.inhibit_changed <= inhibit_changed;
            r_a_word.main_bank_out   <= next_state.main_bank;
            r_a_word.second_d_bank   <= next_state.d_sub_bank;
        end
        if (a_advance && r_a_valid) begin
            r_out_word <= out_word_d;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_in_stall)
        else $error("input taken during RAM clearing sweep");

    a_write_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_busy && !cur_state.write_en |-> !ram_we)
        else $error("RAM written while write enable is off");

    a_stage_a_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_advance |=> r_a_valid && $stable(r_a_word) && $stable(ram_rdata))
        else $error("stage A result lost while output stalled");

endmodule

/* rtl/blcr_ram.sv */
// Single-port 128K x 8 card RAM with registered read data.
// Depends on blcr_pkg for the address width and depth.
module blcr_ram (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic                            i_re,
    input  logic [blcr_pkg::RAM_ADDR_W-1:0] i_addr,
    input  logic [7:0]                      i_wdata,
    output logic [7:0]                      o_rdata
);
    import blcr_pkg::*;

    logic [7:0] r_mem [RAM_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/blcr_switch.sv */
// Soft switch decoder and card state registers (enables, banks, last switch).
// Depends on blcr_pkg for the word and state types.
module blcr_switch (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  blcr_pkg::t_in_word    i_word,
    output blcr_pkg::t_card_state o_state,
    output blcr_pkg::t_card_state o_next,
    output logic                  o_inhibit_changed
);
    import blcr_pkg::*;

    t_card_state r_state, n_state;
    logic        r_prev_valid, n_prev_valid;
    logic [3:0]  r_prev_off, n_prev_off;
    logic        double_off;
    logic        repeat_hit;
    logic [3:0]  off;

    assign off = i_word.switch_offset;
    // 1, 3, 9 and B need two touches of the same switch with no other switch between
    assign double_off = off[0] && !off[2];
    assign repeat_hit = r_prev_valid && (r_prev_off == off);

    always_comb begin
        n_state      = r_state;
        n_prev_valid = r_prev_valid;
        n_prev_off   = r_prev_off;
        if (i_word.operation == OP_SWITCH) begin
            n_prev_valid = 1'b1;
            n_prev_off   = off;
            if (!double_off || repeat_hit) begin
                if (off[2]) begin
                    n_state.main_bank = {off[3], off[1:0]};
                end else begin
                    n_state.write_en   = off[0];
                    n_state.read_en    = (off[1] == off[0]);
                    n_state.d_sub_bank = !off[3];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= '0;
            r_prev_valid <= 1'b0;
            r_prev_off   <= '0;
        end else if (i_accept) begin
            r_state      <= n_state;
            r_prev_valid <= n_prev_valid;
            r_prev_off   <= n_prev_off;
        end
    end

    assign o_state           = r_state;
    assign o_next            = n_state;
    assign o_inhibit_changed = (n_state.read_en != r_state.read_en) ||
                               (n_state.write_en != r_state.write_en);

    // memory and unused operations never touch the switch state
    a_mem_op_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (i_word.operation != OP_SWITCH) |=> $stable(r_state))
        else $error("card state changed on a non-switch word");

endmodule
